// ===== rtl/core/gcode_line_field_parser_macros.svh =====
// Assertion macros for the G-code line field parser.
// Used by the top level only; no other dependencies.
`ifndef GCODE_LINE_FIELD_PARSER_MACROS_SVH
`define GCODE_LINE_FIELD_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
`define GCLP_ASSERT_IMPLY(label, clk, rstn, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (conseq)) \
        else $error("gclp assertion failed");
`define GCLP_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("gclp assertion failed");
`else
`define GCLP_ASSERT_IMPLY(label, clk, rstn, cond, conseq)
`define GCLP_ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

// ===== rtl/core/gclp_pkg.sv =====
// Shared types, codes and constants of the G-code line field parser.
// No dependencies; imported by every module of the block.
package gclp_pkg;

    localparam int FRAC_DIGITS_DEFAULT = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

    localparam logic KIND_FIELD = 1'b0;
    localparam logic KIND_LINE  = 1'b1;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_LETTER  = 2'd1;
    localparam logic [1:0] ERR_EMPTY   = 2'd2;

    localparam logic [3:0] LID_G = 4'd0;
    localparam logic [3:0] LID_M = 4'd1;
    localparam logic [3:0] LID_X = 4'd2;
    localparam logic [3:0] LID_Y = 4'd3;
    localparam logic [3:0] LID_Z = 4'd4;
    localparam logic [3:0] LID_F = 4'd5;
    localparam logic [3:0] LID_E = 4'd6;
    localparam logic [3:0] LID_S = 4'd7;
    localparam logic [3:0] LID_T = 4'd8;

    typedef struct packed {
        logic               kind;
        logic [3:0]         letter_id;
        logic               has_digits;
        logic signed [31:0] value_milli;
        logic               saturated;
        logic               line_ok;
        logic [1:0]         error_code;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic [19:0] pow10(input logic [2:0] n);
        logic [19:0] r;
        case (n)
            3'd0:    r = 20'd1;
            3'd1:    r = 20'd10;
            3'd2:    r = 20'd100;
            3'd3:    r = 20'd1000;
            3'd4:    r = 20'd10000;
            3'd5:    r = 20'd100000;
            3'd6:    r = 20'd1000000;
            default: r = 20'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/gclp_parser.sv =====
// Character parser of the G-code line field parser: phase, number run and
// line state, and the field and line results caused by each character.
// Depends on gclp_pkg.
module gclp_parser #(
    parameter int FRAC_DIGITS = gclp_pkg::FRAC_DIGITS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  logic [7:0]     char_code,
    output gclp_pkg::push_t push
);
    import gclp_pkg::*;

    localparam int FW = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_NUMBER = 2'd1,
        PH_SPACES = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [3:0]    letter_reg, letter_next;
    logic [30:0]   acc_reg, acc_next;
    logic          neg_reg, neg_next;
    logic          dot_reg, dot_next;
    logic [FW-1:0] frac_reg, frac_next;
    logic          stop_reg, stop_next;
    logic          run_reg, run_next;
    logic          clip_reg, clip_next;
    logic          started_reg, started_next;

    logic          is_term;
    logic          is_digit;
    logic          is_run;
    logic          letter_ok;
    logic [3:0]    letter_id;
    logic [34:0]   macc;
    logic          macc_over;
    logic [30:0]   macc_sat;
    logic          fs;
    logic          emit;
    logic          line_valid;
    logic          line_ok;
    logic [1:0]    line_err;
    logic [2:0]    scale_idx;
    logic [50:0]   scaled;
    logic          scale_over;
    logic [30:0]   mag;
    logic [31:0]   mag_ext;
    res_t          field_res;
    res_t          line_res;

    always_comb begin
        letter_ok = 1'b1;
        unique case (char_code)
            CH_G:    letter_id = LID_G;
            CH_M:    letter_id = LID_M;
            CH_X:    letter_id = LID_X;
            CH_Y:    letter_id = LID_Y;
            CH_Z:    letter_id = LID_Z;
            CH_F:    letter_id = LID_F;
            CH_E:    letter_id = LID_E;
            CH_S:    letter_id = LID_S;
            CH_T:    letter_id = LID_T;
            default: begin
                letter_id = LID_G;
                letter_ok = 1'b0;
            end
        endcase
    end

    assign is_term  = (char_code == CH_NUL) || (char_code == CH_LF) ||
                      (char_code == CH_CR) || (char_code == CH_SEMI);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_run   = is_digit || (char_code == CH_DOT) || (char_code == CH_MINUS);

    assign macc      = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                     + {31'b0, char_code[3:0]};
    assign macc_over = macc > {4'b0, MAG_MAX};
    assign macc_sat  = macc_over ? MAG_MAX : macc[30:0];

    // Scale the digits taken to the full number of fraction digits.
    assign scale_idx  = 3'(FRAC_DIGITS) - 3'(frac_reg);
    assign scaled     = 51'(acc_reg) * 51'(pow10(scale_idx));
    assign scale_over = scaled > {20'b0, MAG_MAX};
    assign mag        = !run_reg ? 31'd0 : ((clip_reg || scale_over) ? MAG_MAX : scaled[30:0]);
    assign mag_ext    = {1'b0, mag};

    always_comb begin
        phase_next   = phase_reg;
        letter_next  = letter_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        dot_next     = dot_reg;
        frac_next    = frac_reg;
        stop_next    = stop_reg;
        run_next     = run_reg;
        clip_next    = clip_reg;
        started_next = started_reg;
        fs           = 1'b0;
        emit         = 1'b0;
        line_valid   = 1'b0;
        line_ok      = 1'b0;
        line_err     = ERR_NONE;
        if (step) begin
            unique case (phase_reg)
                PH_NUMBER: begin
                    if (is_run) begin
                        run_next = 1'b1;
                        if (!stop_reg) begin
                            if (char_code == CH_MINUS) begin
                                if (!run_reg) begin
                                    neg_next = 1'b1;
                                end else begin
                                    stop_next = 1'b1;
                                end
                            end else if (char_code == CH_DOT) begin
                                if (dot_reg) begin
                                    stop_next = 1'b1;
                                end else begin
                                    dot_next = 1'b1;
                                end
                            end else if (dot_reg) begin
                                if (frac_reg < FW'(FRAC_DIGITS)) begin
                                    acc_next  = macc_sat;
                                    clip_next = clip_reg | macc_over;
                                    frac_next = frac_reg + FW'(1);
                                end
                            end else begin
                                acc_next  = macc_sat;
                                clip_next = clip_reg | macc_over;
                            end
                        end
                    end else begin
                        emit = 1'b1;
                        if (char_code == CH_SPACE) begin
                            phase_next = PH_SPACES;
                        end else begin
                            fs = 1'b1;
                        end
                    end
                end
                PH_SPACES: begin
                    if (char_code != CH_SPACE) begin
                        fs = 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (char_code == CH_LF) begin
                        phase_next   = PH_START;
                        started_next = 1'b0;
                    end
                end
                PH_START: begin
                    fs = 1'b1;
                end
                default: begin
                    phase_next = PH_START;
                end
            endcase
            if (fs) begin
                if (is_term) begin
                    line_valid   = 1'b1;
                    line_ok      = started_reg;
                    line_err     = started_reg ? ERR_NONE : ERR_EMPTY;
                    started_next = 1'b0;
                    phase_next   = ((char_code == CH_SEMI) || (char_code == CH_CR)) ?
                                   PH_SKIP : PH_START;
                end else if (!letter_ok) begin
                    line_valid   = 1'b1;
                    line_err     = ERR_LETTER;
                    started_next = 1'b0;
                    phase_next   = PH_SKIP;
                end else begin
                    letter_next  = letter_id;
                    started_next = 1'b1;
                    acc_next     = '0;
                    neg_next     = 1'b0;
                    dot_next     = 1'b0;
                    frac_next    = '0;
                    stop_next    = 1'b0;
                    run_next     = 1'b0;
                    clip_next    = 1'b0;
                    phase_next   = PH_NUMBER;
                end
            end
        end
    end

    always_comb begin
        field_res             = '0;
        field_res.kind        = KIND_FIELD;
        field_res.letter_id   = letter_reg;
        field_res.has_digits  = run_reg;
        field_res.value_milli = neg_reg ? -$signed(mag_ext) : $signed(mag_ext);
        field_res.saturated   = run_reg && (clip_reg || scale_over);
        field_res.last        = !line_valid;

        line_res            = '0;
        line_res.kind       = KIND_LINE;
        line_res.line_ok    = line_ok;
        line_res.error_code = line_err;
        line_res.last       = 1'b1;

        push.count  = 2'({1'b0, emit} + {1'b0, line_valid});
        push.first  = emit ? field_res : line_res;
        push.second = line_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            letter_reg  <= '0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            dot_reg     <= 1'b0;
            frac_reg    <= '0;
            stop_reg    <= 1'b0;
            run_reg     <= 1'b0;
            clip_reg    <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            letter_reg  <= letter_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            dot_reg     <= dot_next;
            frac_reg    <= frac_next;
            stop_reg    <= stop_next;
            run_reg     <= run_next;
            clip_reg    <= clip_next;
            started_reg <= started_next;
        end
    end

endmodule

// ===== rtl/core/gclp_result_queue.sv =====
// Result queue of the G-code line field parser: takes up to two results a cycle
// from the parser, hands one a cycle to the output on pop. Depends on gclp_pkg.
module gclp_result_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  gclp_pkg::push_t push,
    input  logic            pop,
    output gclp_pkg::res_t  head,
    output logic            not_empty,
    output logic            room
);
    import gclp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    res_t          q_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign head       = q_reg[rd_reg];
    assign not_empty  = count_reg != '0;
    assign room       = (count_reg <= CW'(QUEUE_DEPTH - 2)) ||
                        ((count_reg == CW'(QUEUE_DEPTH - 1)) && pop);
    assign count_next = count_reg + CW'(push.count) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            q_reg[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            q_reg[wr_reg + PW'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_reg + PW'(push.count);
            rd_reg    <= rd_reg + PW'(pop);
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/gcode_line_field_parser.sv =====
// Results are registered into the result queue as characters are accepted.
// Throughput: one character per cycle while the queue has room; a character
// ending a field and a line gives two results, which leave the four-entry
// result queue one a cycle while m_ready is high. Reset (aresetn low,
// synchronous) empties the queue and returns the parser to the start of a line.
`include "gcode_line_field_parser_macros.svh"

module gcode_line_field_parser #(
    parameter int FRAC_DIGITS = gclp_pkg::FRAC_DIGITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [3:0]         m_letter_id,
    output logic               m_has_digits,
    output logic signed [31:0] m_value_milli,
    output logic               m_saturated,
    output logic               m_line_ok,
    output logic [1:0]         m_error_code,
    output logic               m_last
);
    import gclp_pkg::*;

    push_t push;
    res_t  head;
    logic  step;
    logic  pop;
    logic  pair_well_formed;
    logic  ok_with_error;

    assign step = s_valid && s_ready;
    assign pop  = m_valid && m_ready;

    gclp_parser #(
        .FRAC_DIGITS(FRAC_DIGITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .char_code (s_char_code),
        .push      (push)
    );

    gclp_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (m_valid),
        .room      (s_ready)
    );

    assign m_kind        = head.kind;
    assign m_letter_id   = head.letter_id;
    assign m_has_digits  = head.has_digits;
    assign m_value_milli = head.value_milli;
    assign m_saturated   = head.saturated;
    assign m_line_ok     = head.line_ok;
    assign m_error_code  = head.error_code;
    assign m_last        = head.last;

    assign pair_well_formed = (push.first.kind == KIND_FIELD) && !push.first.last &&
                              (push.second.kind == KIND_LINE);
    assign ok_with_error    = m_valid && m_line_ok && (m_error_code != ERR_NONE);

    `GCLP_ASSERT_IMPLY(a_push_from_item, aclk, aresetn, push.count != 2'd0, step)
    `GCLP_ASSERT_IMPLY(a_pair_is_field_then_line, aclk, aresetn, push.count == 2'd2, pair_well_formed)
    `GCLP_ASSERT_IMPLY(a_empty_accepts, aclk, aresetn, !m_valid, s_ready)
    `GCLP_ASSERT_NEVER(a_line_ok_has_error, aclk, aresetn, ok_with_error)

endmodule

// ===== tb/gclp_tb_pkg.sv =====
// Result tracker for the G-code line field parser testbench: predicts the
// results of every accepted character and checks what the block delivers.
// Depends on gclp_pkg for the result type and the kind, letter and error codes.
package gclp_tb_pkg;

    import gclp_pkg::*;

    localparam int FRAC = FRAC_DIGITS_DEFAULT;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [1:0] {
        PH_START,
        PH_NUMBER,
        PH_SPACES,
        PH_SKIP
    } parse_phase_t;

    function automatic logic [7:0] letter_code(logic [3:0] id);
        case (id)
            LID_G:   return "G";
            LID_M:   return "M";
            LID_X:   return "X";
            LID_Y:   return "Y";
            LID_Z:   return "Z";
            LID_F:   return "F";
            LID_E:   return "E";
            LID_S:   return "S";
            LID_T:   return "T";
            default: return CH_NUL;
        endcase
    endfunction

    class parse_result_checker;
        parse_phase_t phase;
        logic [3:0]   letter;
        logic [30:0]  mag_acc;
        bit           neg;
        bit           dot;
        bit           stopped;
        bit           run_nonempty;
        bit           clip;
        bit           line_started;
        int unsigned  frac_taken;

        res_t pending_results[$];

        int unsigned field_count;
        int unsigned line_count;
        int unsigned clipped_count;
        int unsigned rejected_count;
        int unsigned mismatch_count;

        function new();
            phase        = PH_START;
            letter       = LID_G;
            line_started = 1'b0;
            clear_number();
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void clear_number();
            mag_acc      = '0;
            neg          = 1'b0;
            dot          = 1'b0;
            stopped      = 1'b0;
            run_nonempty = 1'b0;
            clip         = 1'b0;
            frac_taken   = 0;
        endfunction

        function logic [30:0] shift_in_digit(logic [30:0] a, logic [3:0] d);
            logic [63:0] v;
            v = 64'(a) * 64'd10 + 64'(d);
            if (v > 64'(MAG_MAX)) begin
                clip = 1'b1;
                return MAG_MAX;
            end
            return v[30:0];
        endfunction

        function int letter_of(logic [7:0] c);
            for (int i = 0; i <= int'(LID_T); i++) begin
                if (letter_code(4'(i)) == c) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function bit is_terminator(logic [7:0] c);
            return c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_SEMI;
        endfunction

        function bit is_run_char(logic [7:0] c);
            return (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_MINUS;
        endfunction

        function res_t field_result();
            res_t               r;
            logic [30:0]        mag;
            logic signed [31:0] v;
            r   = '0;
            mag = '0;
            if (run_nonempty) begin
                mag = mag_acc;
                if (!clip) begin
                    for (int unsigned i = frac_taken; i < FRAC; i++) begin
                        mag = shift_in_digit(mag, 4'd0);
                    end
                end
                if (clip) begin
                    mag = MAG_MAX;
                end
            end
            v = {1'b0, mag};
            if (neg) begin
                v = -v;
            end
            r.kind        = KIND_FIELD;
            r.letter_id   = letter;
            r.has_digits  = run_nonempty;
            r.value_milli = v;
            r.saturated   = run_nonempty && clip;
            return r;
        endfunction

        function res_t line_result(bit ok, logic [1:0] err);
            res_t r;
            r            = '0;
            r.kind       = KIND_LINE;
            r.line_ok    = ok;
            r.error_code = err;
            return r;
        endfunction

        function void take_run_char(logic [7:0] c);
            bit         first;
            logic [7:0] d;
            first        = !run_nonempty;
            run_nonempty = 1'b1;
            d            = c - CH_ZERO;
            if (stopped) begin
                return;
            end
            if (c == CH_MINUS) begin
                if (first) begin
                    neg = 1'b1;
                end else begin
                    stopped = 1'b1;
                end
            end else if (c == CH_DOT) begin
                if (dot) begin
                    stopped = 1'b1;
                end else begin
                    dot = 1'b1;
                end
            end else if (dot) begin
                if (frac_taken < FRAC) begin
                    mag_acc = shift_in_digit(mag_acc, d[3:0]);
                    frac_taken++;
                end
            end else begin
                mag_acc = shift_in_digit(mag_acc, d[3:0]);
            end
        endfunction

        function void start_field(logic [7:0] c, ref res_t staged[$]);
            int id;
            if (is_terminator(c)) begin
                staged.push_back(line_result(line_started,
                                             line_started ? ERR_NONE : ERR_EMPTY));
                line_started = 1'b0;
                phase = (c == CH_SEMI || c == CH_CR) ? PH_SKIP : PH_START;
                return;
            end
            id = letter_of(c);
            if (id < 0) begin
                staged.push_back(line_result(1'b0, ERR_LETTER));
                line_started = 1'b0;
                phase        = PH_SKIP;
                return;
            end
            letter       = 4'(id);
            line_started = 1'b1;
            clear_number();
            phase = PH_NUMBER;
        endfunction

        // Returns 1 when the character falls in text that is skipped up to LF.
        function bit take_char(logic [7:0] c);
            res_t staged[$];
            res_t tail;
            bit   dropped;
            dropped = 1'b0;
            case (phase)
                PH_NUMBER: begin
                    if (is_run_char(c)) begin
                        take_run_char(c);
                    end else begin
                        staged.push_back(field_result());
                        if (c == CH_SPACE) begin
                            phase = PH_SPACES;
                        end else begin
                            start_field(c, staged);
                        end
                    end
                end
                PH_SPACES: begin
                    if (c != CH_SPACE) begin
                        start_field(c, staged);
                    end
                end
                PH_SKIP: begin
                    dropped = 1'b1;
                    if (c == CH_LF) begin
                        phase        = PH_START;
                        line_started = 1'b0;
                    end
                end
                default: begin
                    start_field(c, staged);
                end
            endcase
            if (staged.size() > 0) begin
                tail      = staged.pop_back();
                tail.last = 1'b1;
                staged.push_back(tail);
            end
            foreach (staged[i]) begin
                pending_results.push_back(staged[i]);
            end
            return dropped;
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_result(res_t got);
            res_t want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %p", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.letter_id !== want.letter_id)
                report_mismatch($sformatf("letter_id %0d, expected %0d",
                                          got.letter_id, want.letter_id));
            if (got.has_digits !== want.has_digits)
                report_mismatch($sformatf("has_digits %0d, expected %0d",
                                          got.has_digits, want.has_digits));
            if (got.value_milli !== want.value_milli)
                report_mismatch($sformatf("value_milli %0d, expected %0d",
                                          got.value_milli, want.value_milli));
            if (got.saturated !== want.saturated)
                report_mismatch($sformatf("saturated %0d, expected %0d",
                                          got.saturated, want.saturated));
            if (got.line_ok !== want.line_ok)
                report_mismatch($sformatf("line_ok %0d, expected %0d",
                                          got.line_ok, want.line_ok));
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("error_code %0d, expected %0d",
                                          got.error_code, want.error_code));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
            if (want.kind == KIND_FIELD) begin
                field_count++;
                if (want.saturated) clipped_count++;
            end else begin
                line_count++;
                if (!want.line_ok) rejected_count++;
            end
        endtask
    endclass

endpackage

// ===== tb/gcode_line_field_parser_test.sv =====
// Top-level testbench of gcode_line_field_parser: streams directed and random
// G-code text under varying idling and checks every result against predictions.
// Depends on gclp_pkg, gclp_tb_pkg and the parser RTL.
module gcode_line_field_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gclp_pkg::*;
    import gclp_tb_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int ITEMS_PER_PHASE = 550;
    localparam int HOLD_CYCLES     = 60;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 10;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic [7:0]         s_char_code = '0;
    logic               m_ready     = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic               m_kind;
    logic [3:0]         m_letter_id;
    logic               m_has_digits;
    logic signed [31:0] m_value_milli;
    logic               m_saturated;
    logic               m_line_ok;
    logic [1:0]         m_error_code;
    logic               m_last;

    parse_result_checker results = new();

    int          send_idle_pct = 11;
    int          recv_idle_pct = 59;
    int          hold_requests = 0;
    int unsigned chars_sent    = 0;
    int unsigned chars_parsed  = 0;

    gcode_line_field_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_letter_id   (m_letter_id),
        .m_has_digits  (m_has_digits),
        .m_value_milli (m_value_milli),
        .m_saturated   (m_saturated),
        .m_line_ok     (m_line_ok),
        .m_error_code  (m_error_code),
        .m_last        (m_last)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    task automatic send_char(logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
        if (!results.take_char(c)) chars_parsed++;
    endtask

    task automatic send_text(ref logic [7:0] text[$]);
        foreach (text[i]) begin
            send_char(text[i]);
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results.pending() != 0);
    endtask

    function automatic void add_digits(ref logic [7:0] text[$], input int n);
        repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void add_number(ref logic [7:0] text[$]);
        if ($urandom_range(0, 99) < 10) return;
        if ($urandom_range(0, 99) < 30) text.push_back(CH_MINUS);
        add_digits(text, ($urandom_range(0, 99) < 10) ? $urandom_range(8, 12)
                                                      : $urandom_range(0, 4));
        if ($urandom_range(0, 1) == 1) begin
            text.push_back(CH_DOT);
            add_digits(text, $urandom_range(0, 5));
        end
        if ($urandom_range(0, 99) < 10) begin
            text.push_back(($urandom_range(0, 1) == 1) ? CH_MINUS : CH_DOT);
            add_digits(text, $urandom_range(0, 2));
        end
    endfunction

    function automatic void build_line(ref logic [7:0] text[$]);
        int         pick;
        int         n_fields;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
            text.push_back(CH_LF);
            return;
        end
        n_fields = (pick < 13) ? 0 : $urandom_range(1, 4);
        repeat (n_fields) begin
            if ($urandom_range(0, 99) < 4) begin
                text.push_back(8'($urandom_range(0, 255)));
            end else begin
                text.push_back(letter_code(4'($urandom_range(0, int'(LID_T)))));
            end
            add_number(text);
            repeat ($urandom_range(0, 2)) text.push_back(CH_SPACE);
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            text.push_back(CH_LF);
        end else if (pick < 85) begin
            text.push_back((pick < 70) ? CH_SEMI : CH_CR);
            repeat ($urandom_range(0, 6)) begin
                b = 8'($urandom_range(0, 255));
                text.push_back((b == CH_LF) ? CH_SPACE : b);
            end
            text.push_back(CH_LF);
        end else begin
            text.push_back(CH_NUL);
        end
    endfunction

    task automatic run_random_lines(int target);
        logic [7:0]  text[$];
        int unsigned start_count;
        start_count = chars_sent;
        while (chars_sent - start_count < target) begin
            text.delete();
            build_line(text);
            send_text(text);
        end
    endtask

    // Receiver: checks accepted results and drives m_ready, including one
    // long hold-off counted here so that the result queue fills.
    initial begin
        res_t got;
        int   hold_left;
        int   hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.kind        = m_kind;
                got.letter_id   = m_letter_id;
                got.has_digits  = m_has_digits;
                got.value_milli = m_value_milli;
                got.saturated   = m_saturated;
                got.line_ok     = m_line_ok;
                got.error_code  = m_error_code;
                got.last        = m_last;
                results.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [7:0] text[$];
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty line, truncated fraction, minus-only run, NUL in skipped text,
        // unknown letters, dot-only run before CR, empty run before NUL.
        text = '{CH_LF, "G", "-", "1", ".", "2", "3", "4", "5", CH_SPACE,
                 "M", "-", CH_SEMI, CH_NUL, CH_LF, "q", CH_LF, 8'hFF, CH_LF,
                 "Z", CH_DOT, CH_CR, CH_LF, "T", CH_NUL};
        send_text(text);
        run_random_lines(ITEMS_PER_PHASE);

        hold_requests++;
        send_idle_pct = 59;
        recv_idle_pct = 11;
        run_random_lines(ITEMS_PER_PHASE);

        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_lines(ITEMS_PER_PHASE);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Streamed %0d characters (%0d outside skipped text) under three idling mixes.",
                 chars_sent, chars_parsed);
        $display("Checked %0d field results (%0d clipped) and %0d line results (%0d rejected).",
                 results.field_count, results.clipped_count,
                 results.line_count, results.rejected_count);
        if (results.mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", results.mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
